// ===== hw/rtl/cplm_pkg.sv =====
// Package: shared types and constants for the controller poll link manager.
package cplm_pkg;

    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned THRESH_W   = 4;
    localparam int unsigned CMD_W      = 24;
    localparam int unsigned IDENT_W    = 31;
    localparam int unsigned RX_W       = 32;
    localparam int unsigned BITS_W     = 6;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUTS_TO_DISC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_CMD        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_RUMBLE_CMD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID     = 3'd6;

    localparam logic [INTERVAL_W-1:0] PROBE_INTERVAL_RST  = 16'd12000;
    localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RST   = 16'd1500;
    localparam logic [INTERVAL_W-1:0] RESP_TIMEOUT_RST    = 16'd1000;
    localparam logic [THRESH_W-1:0]   TIMEOUTS_TO_DISC_RST = 4'd2;
    localparam logic [CMD_W-1:0]      POLL_CMD_RST        = 24'h400300;
    localparam logic [CMD_W-1:0]      POLL_RUMBLE_CMD_RST = 24'h400301;
    localparam logic [IDENT_W-1:0]    EXPECTED_ID_RST     = 31'h90020;

    localparam logic [CMD_W-1:0]      PROBE_WORD = 24'h000000;
    localparam logic [BITS_W-1:0]     PROBE_BITS = 6'd8;
    localparam logic [BITS_W-1:0]     POLL_BITS  = 6'd24;
    localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = '1;
    localparam logic [COUNT_W-1:0]    COUNT_MAX   = '1;

    // Item kinds carried on s_tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_WORD = 1'b1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] probe_interval_us;
        logic [INTERVAL_W-1:0] poll_interval_us;
        logic [INTERVAL_W-1:0] response_timeout_us;
        logic [THRESH_W-1:0]   timeouts_to_disconnect;
        logic [CMD_W-1:0]      poll_command;
        logic [CMD_W-1:0]      poll_rumble_command;
        logic [IDENT_W-1:0]    expected_identity;
    } cplm_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] timeout_run;
        logic               awaiting_reply;
        logic               connected;
        logic               timed_out;
        logic [BITS_W-1:0]  send_bits;
        logic [CMD_W-1:0]   send_word;
        logic               send_valid;
    } cplm_result_t;

endpackage

// ===== hw/rtl/cplm_cfg.sv =====
// Configuration register file for the poll link manager.
module cplm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cplm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cplm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cplm_pkg::cplm_cfg_t               cfg
);
    import cplm_pkg::*;

    cplm_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.probe_interval_us      <= PROBE_INTERVAL_RST;
            cfg_reg.poll_interval_us       <= POLL_INTERVAL_RST;
            cfg_reg.response_timeout_us    <= RESP_TIMEOUT_RST;
            cfg_reg.timeouts_to_disconnect <= TIMEOUTS_TO_DISC_RST;
            cfg_reg.poll_command           <= POLL_CMD_RST;
            cfg_reg.poll_rumble_command    <= POLL_RUMBLE_CMD_RST;
            cfg_reg.expected_identity      <= EXPECTED_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROBE_INTERVAL:
                    cfg_reg.probe_interval_us <= cfg_data[INTERVAL_W-1:0];
                REG_POLL_INTERVAL:
                    cfg_reg.poll_interval_us <= cfg_data[INTERVAL_W-1:0];
                REG_RESP_TIMEOUT:
                    cfg_reg.response_timeout_us <= cfg_data[INTERVAL_W-1:0];
                REG_TIMEOUTS_TO_DISC:
                    cfg_reg.timeouts_to_disconnect <= cfg_data[THRESH_W-1:0];
                REG_POLL_CMD:
                    cfg_reg.poll_command <= cfg_data[CMD_W-1:0];
                REG_POLL_RUMBLE_CMD:
                    cfg_reg.poll_rumble_command <= cfg_data[CMD_W-1:0];
                REG_EXPECTED_ID:
                    cfg_reg.expected_identity <= cfg_data[IDENT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/cplm_step.sv =====
// Link state registers and the per-item next-state and result logic.
module cplm_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          op,
    input  logic [cplm_pkg::RX_W-1:0]     rx_word,
    input  logic                          rumble_on,
    input  cplm_pkg::cplm_cfg_t           cfg,
    output cplm_pkg::cplm_result_t        res
);
    import cplm_pkg::*;

    logic [INTERVAL_W-1:0] elapsed_reg, elapsed_next;
    logic                  link_up_reg, link_up_next;
    logic                  waiting_reg, waiting_next;
    logic [COUNT_W-1:0]    tmo_count_reg, tmo_count_next;

    logic [INTERVAL_W-1:0] elapsed_tick;
    logic [COUNT_W-1:0]    tmo_count_inc;

    always_comb
    begin
        elapsed_tick = elapsed_reg;
        if (op == OP_TICK && elapsed_reg != ELAPSED_MAX)
            elapsed_tick = elapsed_reg + 1'b1;

        tmo_count_inc = tmo_count_reg;
        if (tmo_count_reg != COUNT_MAX)
            tmo_count_inc = tmo_count_reg + 1'b1;

        elapsed_next   = elapsed_tick;
        link_up_next   = link_up_reg;
        waiting_next   = waiting_reg;
        tmo_count_next = tmo_count_reg;
        res            = '0;

        if (waiting_reg)
        begin
            if (elapsed_tick < cfg.response_timeout_us)
            begin
                // only a word with its end bit closes the wait
                if (op == OP_WORD && rx_word[0])
                begin
                    if (rx_word[RX_W-1:1] == cfg.expected_identity)
                    begin
                        link_up_next   = 1'b1;
                        tmo_count_next = '0;
                    end
                    waiting_next = 1'b0;
                end
            end
            else
            begin
                tmo_count_next = tmo_count_inc;
                waiting_next   = 1'b0;
                res.timed_out  = 1'b1;
                if (link_up_reg &&
                    tmo_count_inc >= {{(COUNT_W-THRESH_W){1'b0}}, cfg.timeouts_to_disconnect})
                    link_up_next = 1'b0;
            end
        end
        else
        begin
            if (!link_up_reg && elapsed_tick > cfg.probe_interval_us)
            begin
                res.send_valid = 1'b1;
                res.send_word  = PROBE_WORD;
                res.send_bits  = PROBE_BITS;
            end
            else if (link_up_reg && elapsed_tick > cfg.poll_interval_us)
            begin
                res.send_valid = 1'b1;
                res.send_word  = rumble_on ? cfg.poll_rumble_command : cfg.poll_command;
                res.send_bits  = POLL_BITS;
            end
            if (res.send_valid)
            begin
                waiting_next = 1'b1;
                elapsed_next = '0;
            end
        end

        res.connected      = link_up_next;
        res.awaiting_reply = waiting_next;
        res.timeout_run    = tmo_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            link_up_reg   <= 1'b0;
            waiting_reg   <= 1'b0;
            tmo_count_reg <= '0;
        end
        else if (step_en)
        begin
            elapsed_reg   <= elapsed_next;
            link_up_reg   <= link_up_next;
            waiting_reg   <= waiting_next;
            tmo_count_reg <= tmo_count_next;
        end
    end

    a_send_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.send_valid |=> waiting_reg && elapsed_reg == '0)
        else $error("send did not start a reply wait");

    a_timeout_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.timed_out |=> !waiting_reg)
        else $error("timeout left the wait open");

    a_no_send_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && waiting_reg |-> !res.send_valid)
        else $error("command sent while a reply was awaited");

    a_timeout_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.timed_out |-> waiting_reg && !res.send_valid)
        else $error("timeout flagged outside a reply wait");

endmodule

// ===== hw/rtl/controller_poll_link_manager_unit.sv =====
// Top level: input register, link step logic and output register.
// An accepted item is held in the input register, and its result in the output register.
// Throughput: one item per cycle while m_tready is high; the link state update is a single
// compare-and-select pass between the input register and the output register.
// Reset (rst_n, async, active low) clears link state and both stages and loads the
// default configuration; no clearing pass, items are taken right after reset.
module controller_poll_link_manager_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cplm_pkg::IN_DATA_W-1:0]    s_tdata,   // rx_word[31:0], rumble_on[32], zero pad
    input  logic                              s_tuser,   // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cplm_pkg::OUT_DATA_W-1:0]   m_tdata,   // send_valid, send_word[24], send_bits[6],
                                                         // timed_out, connected, awaiting_reply,
                                                         // timeout_run[8], zero pad
    input  logic                              cfg_we,
    input  logic [cplm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cplm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cplm_pkg::*;

    localparam int unsigned RES_W = $bits(cplm_result_t);

    cplm_cfg_t    cfg;
    cplm_result_t res;
    cplm_result_t out_reg;

    logic            in_valid_reg;
    logic            in_op_reg;
    logic [RX_W-1:0] in_word_reg;
    logic            in_rumble_reg;
    logic            out_valid_reg;

    logic advance;
    logic step_en;
    logic in_take;

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    cplm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cplm_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .op        (in_op_reg),
        .rx_word   (in_word_reg),
        .rumble_on (in_rumble_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step_en)
                in_valid_reg <= 1'b0;

            if (step_en)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg     <= s_tuser;
            in_word_reg   <= s_tdata[RX_W-1:0];
            in_rumble_reg <= s_tdata[RX_W];
        end
        if (step_en)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_reg};

endmodule
